FILE: rtl/vcsf_pkg.sv
package vcsf_pkg;

  localparam int VEL_W      = 16;
  localparam int DIST_W     = 16;
  localparam int LIM_W      = 15;
  localparam int MODE_W     = 4;
  localparam int FRAC_W     = 16;
  localparam int Q_W        = FRAC_W + 1;   // Q1.16 factor, up to and including 1.0
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // one quotient bit per divider stage
  localparam int DIV_STAGES = Q_W;
  localparam int NUM_LANES  = 2;
  localparam int LANE_FRONT = 0;
  localparam int LANE_SIDE  = 1;

  localparam logic [Q_W-1:0] ONE_Q16             = Q_W'(65536);
  localparam logic [Q_W-1:0] MIN_SLOW_FACTOR_Q16 = Q_W'(13107);
  localparam logic [Q_W-1:0] SIDE_FLOOR_Q16      = Q_W'(13107);

  localparam int MODE_EN           = 0;
  localparam int MODE_FRONT_FS     = 1;
  localparam int MODE_SIDE_FS      = 2;
  localparam int MODE_TURN_AT_STOP = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LINEAR,
    REG_MAX_ANGULAR,
    REG_FRONT_STOP,
    REG_FRONT_SLOW,
    REG_SIDE_STOP,
    REG_SIDE_SLOW,
    REG_STOP_TURN_LIMIT,
    REG_MODE_FLAGS
  } reg_idx_t;

  typedef enum logic [3:0] {
    CAUSE_NONE,
    CAUSE_CLAMP,
    CAUSE_FRONT_INVALID,
    CAUSE_FRONT_STOP,
    CAUSE_FRONT_SLOW,
    CAUSE_LEFT_INVALID,
    CAUSE_LEFT_NEAR,
    CAUSE_RIGHT_INVALID,
    CAUSE_RIGHT_NEAR
  } cause_t;

  typedef struct packed {
    logic [LIM_W-1:0]  max_linear;
    logic [LIM_W-1:0]  max_angular;
    logic [DIST_W-1:0] front_stop;
    logic [DIST_W-1:0] front_slow;
    logic [DIST_W-1:0] side_stop;
    logic [DIST_W-1:0] side_slow;
    logic [LIM_W-1:0]  stop_turn_limit;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_linear:      LIM_W'(500),
    max_angular:     LIM_W'(2000),
    front_stop:      DIST_W'(250),
    front_slow:      DIST_W'(600),
    side_stop:       DIST_W'(150),
    side_slow:       DIST_W'(350),
    stop_turn_limit: LIM_W'(800),
    mode:            MODE_W'(15)
  };

  // after the magnitude clamp
  typedef struct packed {
    logic signed [VEL_W-1:0] v;
    logic signed [VEL_W-1:0] w;
    logic                    lim;
    logic                    f_ok;
    logic                    l_ok;
    logic                    r_ok;
    logic [DIST_W-1:0]       fd;
    logic [DIST_W-1:0]       ld;
    logic [DIST_W-1:0]       rd;
  } clamp_t;

  // decided command; v and w still need the slow factor where scale_* is set
  typedef struct packed {
    logic signed [VEL_W-1:0] v;
    logic signed [VEL_W-1:0] w;
    logic                    scale_v;
    logic                    scale_w;
    logic                    lim;
    logic                    emg;
    cause_t                  cause;
  } res_t;

  typedef struct packed {
    logic [DIST_W-1:0] num;
    logic [DIST_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    res_t     res;
    div_req_t front;
    div_req_t side;
  } dec_t;

  typedef struct packed {
    res_t           res;
    logic [Q_W-1:0] fq;
    logic [Q_W-1:0] sq;
  } div_out_t;

  function automatic logic signed [VEL_W-1:0] clamp_mag(logic signed [VEL_W-1:0] x,
                                                       logic [LIM_W-1:0] lim);
    logic signed [VEL_W:0] xs;
    logic signed [VEL_W:0] ls;
    xs = (VEL_W+1)'(x);
    ls = (VEL_W+1)'(lim);
    if (xs > ls) begin
      clamp_mag = VEL_W'(ls);
    end else if (xs < -ls) begin
      clamp_mag = VEL_W'(-ls);
    end else begin
      clamp_mag = x;
    end
  endfunction

  function automatic logic [Q_W-1:0] sat_factor(logic [Q_W-1:0] q, logic [Q_W-1:0] floor_q);
    sat_factor = (q > ONE_Q16) ? ONE_Q16 : ((q < floor_q) ? floor_q : q);
  endfunction

endpackage

FILE: rtl/vcsf_if.sv
interface vcsf_in_if;
  import vcsf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] linear_cmd;
  logic signed [VEL_W-1:0] angular_cmd;
  logic [DIST_W-1:0]       front_dist;
  logic [DIST_W-1:0]       left_dist;
  logic [DIST_W-1:0]       right_dist;
  logic                    front_good;
  logic                    left_good;
  logic                    right_good;

  modport source (output valid, linear_cmd, angular_cmd, front_dist, left_dist, right_dist,
                  front_good, left_good, right_good, input ready);
  modport sink (input valid, linear_cmd, angular_cmd, front_dist, left_dist, right_dist,
                front_good, left_good, right_good, output ready);
endinterface

interface vcsf_out_if;
  import vcsf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] linear_out;
  logic signed [VEL_W-1:0] angular_out;
  logic                    was_limited;
  logic                    emergency;
  logic [3:0]              first_cause;

  modport source (output valid, linear_out, angular_out, was_limited, emergency, first_cause,
                  input ready);
  modport sink (input valid, linear_out, angular_out, was_limited, emergency, first_cause,
                output ready);
endinterface

interface vcsf_cfg_if;
  import vcsf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/vcsf_cfg_regs.sv
module vcsf_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  vcsf_cfg_if.sink       cfg_ch,
  output vcsf_pkg::cfg_t cfg
);
  import vcsf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_MAX_LINEAR:      cfg_nxt.max_linear      = cfg_ch.data[LIM_W-1:0];
        REG_MAX_ANGULAR:     cfg_nxt.max_angular     = cfg_ch.data[LIM_W-1:0];
        REG_FRONT_STOP:      cfg_nxt.front_stop      = cfg_ch.data[DIST_W-1:0];
        REG_FRONT_SLOW:      cfg_nxt.front_slow      = cfg_ch.data[DIST_W-1:0];
        REG_SIDE_STOP:       cfg_nxt.side_stop       = cfg_ch.data[DIST_W-1:0];
        REG_SIDE_SLOW:       cfg_nxt.side_slow       = cfg_ch.data[DIST_W-1:0];
        REG_STOP_TURN_LIMIT: cfg_nxt.stop_turn_limit = cfg_ch.data[LIM_W-1:0];
        REG_MODE_FLAGS:      cfg_nxt.mode            = cfg_ch.data[MODE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/vcsf_decide.sv
module vcsf_decide (
  input  logic           clk,
  input  logic           rst_n,
  input  vcsf_pkg::cfg_t cfg,
  vcsf_in_if.sink        in_ch,
  output logic           dec_valid,
  input  logic           dec_ready,
  output vcsf_pkg::dec_t dec
);
  import vcsf_pkg::*;

  function automatic cause_t keep_first(cause_t cur, cause_t c);
    keep_first = (cur == CAUSE_NONE) ? c : cur;
  endfunction

  logic   a_vld_r;
  logic   a_rdy;
  clamp_t a_r;
  clamp_t a_nxt;
  logic   b_vld_r;
  logic   b_rdy;
  dec_t   b_r;
  dec_t   b_nxt;

  logic signed [VEL_W-1:0] v_f;
  logic signed [VEL_W-1:0] w_f;
  logic                    left;
  logic [DIST_W-1:0]       sd;
  logic                    s_ok;
  cause_t                  c_inv;
  cause_t                  c_near;

  assign b_rdy       = !b_vld_r || dec_ready;
  assign a_rdy       = !a_vld_r || b_rdy;
  assign in_ch.ready = a_rdy;
  assign dec_valid   = b_vld_r;
  assign dec         = b_r;

  // stage A: magnitude clamp, sensor validity
  always_comb begin
    a_nxt.v   = in_ch.linear_cmd;
    a_nxt.w   = in_ch.angular_cmd;
    a_nxt.lim = 1'b0;
    if (cfg.mode[MODE_EN]) begin
      a_nxt.v   = clamp_mag(in_ch.linear_cmd, cfg.max_linear);
      a_nxt.w   = clamp_mag(in_ch.angular_cmd, cfg.max_angular);
      a_nxt.lim = (a_nxt.v != in_ch.linear_cmd) || (a_nxt.w != in_ch.angular_cmd);
    end
    a_nxt.f_ok = in_ch.front_good && (in_ch.front_dist != '0);
    a_nxt.l_ok = in_ch.left_good && (in_ch.left_dist != '0);
    a_nxt.r_ok = in_ch.right_good && (in_ch.right_dist != '0);
    a_nxt.fd   = in_ch.front_dist;
    a_nxt.ld   = in_ch.left_dist;
    a_nxt.rd   = in_ch.right_dist;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_rdy) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_ch.valid) begin
      a_r <= a_nxt;
    end
  end

  // stage B: front and side rules, divider operands
  always_comb begin
    b_nxt           = '0;
    b_nxt.res.lim   = a_r.lim;
    b_nxt.res.cause = a_r.lim ? CAUSE_CLAMP : CAUSE_NONE;
    v_f             = a_r.v;
    w_f             = a_r.w;

    if (cfg.mode[MODE_EN] && v_f > 0) begin
      if (!a_r.f_ok) begin
        if (cfg.mode[MODE_FRONT_FS]) begin
          v_f             = '0;
          b_nxt.res.emg   = 1'b1;
          b_nxt.res.lim   = 1'b1;
          b_nxt.res.cause = keep_first(b_nxt.res.cause, CAUSE_FRONT_INVALID);
        end
      end else if (a_r.fd <= cfg.front_stop) begin
        v_f             = '0;
        b_nxt.res.emg   = 1'b1;
        b_nxt.res.lim   = 1'b1;
        b_nxt.res.cause = keep_first(b_nxt.res.cause, CAUSE_FRONT_STOP);
        w_f = cfg.mode[MODE_TURN_AT_STOP] ? clamp_mag(w_f, cfg.stop_turn_limit) : '0;
      end else if (a_r.fd <= cfg.front_slow) begin
        b_nxt.res.scale_v = 1'b1;
        b_nxt.res.lim     = 1'b1;
        b_nxt.res.cause   = keep_first(b_nxt.res.cause, CAUSE_FRONT_SLOW);
      end
    end

    // turn direction picks the side that is checked
    left   = !w_f[VEL_W-1];
    sd     = left ? a_r.ld : a_r.rd;
    s_ok   = left ? a_r.l_ok : a_r.r_ok;
    c_inv  = left ? CAUSE_LEFT_INVALID : CAUSE_RIGHT_INVALID;
    c_near = left ? CAUSE_LEFT_NEAR : CAUSE_RIGHT_NEAR;

    if (cfg.mode[MODE_EN] && w_f != '0) begin
      if (!s_ok) begin
        if (cfg.mode[MODE_SIDE_FS]) begin
          w_f             = '0;
          b_nxt.res.lim   = 1'b1;
          b_nxt.res.cause = keep_first(b_nxt.res.cause, c_inv);
        end
      end else if (sd <= cfg.side_stop) begin
        w_f             = '0;
        b_nxt.res.lim   = 1'b1;
        b_nxt.res.cause = keep_first(b_nxt.res.cause, c_near);
      end else if (sd <= cfg.side_slow) begin
        b_nxt.res.scale_w = 1'b1;
        b_nxt.res.lim     = 1'b1;
        b_nxt.res.cause   = keep_first(b_nxt.res.cause, c_near);
      end
    end

    b_nxt.res.v     = v_f;
    b_nxt.res.w     = w_f;
    b_nxt.front.num = a_r.fd - cfg.front_stop;
    b_nxt.front.den = cfg.front_slow - cfg.front_stop;
    b_nxt.side.num  = sd - cfg.side_stop;
    b_nxt.side.den  = cfg.side_slow - cfg.side_stop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_rdy) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_vld_r) begin
      b_r <= b_nxt;
    end
  end

endmodule

FILE: rtl/vcsf_div.sv
module vcsf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vcsf_pkg::dec_t     in_dec,
  output logic               out_valid,
  input  logic               out_ready,
  output vcsf_pkg::div_out_t out_div
);
  import vcsf_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  // restoring divider, both lanes side by side: (num << 16) / den with num <= den
  logic              vld_r [DIV_STAGES];
  logic              rdy   [DIV_STAGES];
  res_t              res_r [DIV_STAGES];
  logic [DIST_W-1:0] rem_r [DIV_STAGES][NUM_LANES];
  logic [DIST_W-1:0] den_r [DIV_STAGES][NUM_LANES];
  logic [Q_W-1:0]    quo_r [DIV_STAGES][NUM_LANES];
  div_req_t          req   [NUM_LANES];

  assign req[LANE_FRONT] = in_dec.front;
  assign req[LANE_SIDE]  = in_dec.side;

  assign in_ready      = rdy[0];
  assign out_valid     = vld_r[LAST];
  assign out_div.res   = res_r[LAST];
  assign out_div.fq    = quo_r[LAST][LANE_FRONT];
  assign out_div.sq    = quo_r[LAST][LANE_SIDE];

  for (genvar k = 0; k < LAST; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end
  assign rdy[LAST] = !vld_r[LAST] || out_ready;

  // first stage settles the integer bit (quotient of exactly 1.0)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      res_r[0] <= in_dec.res;
      for (int l = 0; l < NUM_LANES; l++) begin
        den_r[0][l] <= req[l].den;
        if (req[l].num >= req[l].den) begin
          rem_r[0][l] <= req[l].num - req[l].den;
          quo_r[0][l] <= ONE_Q16;
        end else begin
          rem_r[0][l] <= req[l].num;
          quo_r[0][l] <= '0;
        end
      end
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
    logic [DIST_W:0]   trial   [NUM_LANES];
    logic              ge      [NUM_LANES];
    logic [DIST_W-1:0] rem_nxt [NUM_LANES];
    logic [Q_W-1:0]    quo_nxt [NUM_LANES];

    always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trial[l]   = {rem_r[k-1][l], 1'b0};
        ge[l]      = trial[l] >= {1'b0, den_r[k-1][l]};
        rem_nxt[l] = ge[l] ? DIST_W'(trial[l] - {1'b0, den_r[k-1][l]})
                           : trial[l][DIST_W-1:0];
        quo_nxt[l] = quo_r[k-1][l];
        quo_nxt[l][Q_W-1-k] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld_r[k-1]) begin
        res_r[k] <= res_r[k-1];
        for (int l = 0; l < NUM_LANES; l++) begin
          den_r[k][l] <= den_r[k-1][l];
          rem_r[k][l] <= rem_nxt[l];
          quo_r[k][l] <= quo_nxt[l];
        end
      end
    end
  end

endmodule

FILE: rtl/vcsf_scale.sv
module vcsf_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vcsf_pkg::div_out_t in_div,
  vcsf_out_if.source         out_ch
);
  import vcsf_pkg::*;

  logic       m_vld_r;
  logic       m_rdy;
  res_t       m_res_r;
  logic [LIM_W-1:0] m_vmag_r;
  logic [LIM_W-1:0] m_wmag_r;

  logic [Q_W-1:0]       f_front;
  logic [Q_W-1:0]       f_side;
  logic [LIM_W-1:0]     vmag;
  logic [LIM_W-1:0]     wmag;
  logic [LIM_W+Q_W-1:0] prod_v;
  logic [LIM_W+Q_W-1:0] prod_w;

  logic                    o_vld_r;
  logic                    o_rdy;
  logic signed [VEL_W-1:0] o_v_r;
  logic signed [VEL_W-1:0] o_w_r;
  logic                    o_lim_r;
  logic                    o_emg_r;
  cause_t                  o_cause_r;
  logic signed [VEL_W-1:0] o_v_nxt;
  logic signed [VEL_W-1:0] o_w_nxt;

  assign o_rdy    = !o_vld_r || out_ch.ready;
  assign m_rdy    = !m_vld_r || o_rdy;
  assign in_ready = m_rdy;

  // multiply stage: magnitudes never exceed 15 bits after the clamp
  always_comb begin
    f_front = sat_factor(in_div.fq, MIN_SLOW_FACTOR_Q16);
    f_side  = sat_factor(in_div.sq, SIDE_FLOOR_Q16);
    vmag    = in_div.res.v[LIM_W-1:0];
    wmag    = in_div.res.w[VEL_W-1] ? LIM_W'(-in_div.res.w) : in_div.res.w[LIM_W-1:0];
    prod_v  = vmag * f_front;
    prod_w  = wmag * f_side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (m_rdy) begin
      m_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && in_valid) begin
      m_res_r  <= in_div.res;
      m_vmag_r <= prod_v[FRAC_W +: LIM_W];
      m_wmag_r <= prod_w[FRAC_W +: LIM_W];
    end
  end

  // output register: restore the sign of the scaled turn
  always_comb begin
    o_v_nxt = m_res_r.scale_v ? {1'b0, m_vmag_r} : m_res_r.v;
    o_w_nxt = m_res_r.w;
    if (m_res_r.scale_w) begin
      o_w_nxt = m_res_r.w[VEL_W-1] ? -{1'b0, m_wmag_r} : {1'b0, m_wmag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_rdy) begin
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && m_vld_r) begin
      o_v_r     <= o_v_nxt;
      o_w_r     <= o_w_nxt;
      o_lim_r   <= m_res_r.lim;
      o_emg_r   <= m_res_r.emg;
      o_cause_r <= m_res_r.cause;
    end
  end

  assign out_ch.valid       = o_vld_r;
  assign out_ch.linear_out  = o_v_r;
  assign out_ch.angular_out = o_w_r;
  assign out_ch.was_limited = o_lim_r;
  assign out_ch.emergency   = o_emg_r;
  assign out_ch.first_cause = o_cause_r;

endmodule

FILE: rtl/velocity_command_safety_filter.sv
// Velocity command safety filter.
// in_ch carries one command word: linear and angular velocity plus front, left
// and right distances with their good bits. out_ch returns one word per command:
// the safe velocities, a limited flag, an emergency flag and the first cause.
// cfg_ch writes the limit, distance and mode registers by index; it is always
// ready and should only be used while no command is in flight.
// Throughput: one word per cycle while out_ch does not stall. A word passes from
// acceptance on in_ch to valid on out_ch through clamp, rule decision, 17-stage divider
// at one quotient bit per stage, multiply and output register; the divider sets the depth.
// Reset (rst_n low, synchronous) loads the register defaults and empties the
// pipeline. When out_ch stalls, each stage holds its word and empty stages
// still fill, so in_ch.ready drops only once every stage holds a word.
module velocity_command_safety_filter (
  input logic         clk,
  input logic         rst_n,
  vcsf_in_if.sink     in_ch,
  vcsf_out_if.source  out_ch,
  vcsf_cfg_if.sink    cfg_ch
);
  import vcsf_pkg::*;

  cfg_t     cfg;
  logic     dec_valid;
  logic     dec_ready;
  dec_t     dec;
  logic     divo_valid;
  logic     divo_ready;
  div_out_t divo;

  vcsf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  vcsf_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  vcsf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_dec    (dec),
    .out_valid (divo_valid),
    .out_ready (divo_ready),
    .out_div   (divo)
  );

  vcsf_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (divo_valid),
    .in_ready (divo_ready),
    .in_div   (divo),
    .out_ch   (out_ch)
  );

  a_emg_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.emergency |-> out_ch.linear_out == '0)
    else $error("emergency word with nonzero linear speed");

  a_cause_matches_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.was_limited == (out_ch.first_cause != CAUSE_NONE))
    else $error("limited flag and first cause disagree");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid straight after reset");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while the output register is empty");

endmodule
